// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is held low.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion with no reset qualifier.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/vts_pkg.sv -----
// ----------------------------------------------------------------------------
// vts_pkg
// Shared types and constants of the vehicle target speed block.
// ----------------------------------------------------------------------------
package vts_pkg;

  localparam int unsigned DivSteps  = 16;
  localparam int unsigned SqrtSteps = 21;
  localparam int unsigned CntW      = 5;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_MIN_GAP     = 3'd0;
  localparam logic [2:0] REG_HEADWAY     = 3'd1;
  localparam logic [2:0] REG_STOP_REACT  = 3'd2;
  localparam logic [2:0] REG_DECEL       = 3'd3;
  localparam logic [2:0] REG_STOP_OFFSET = 3'd4;

  typedef enum logic [1:0] {
    FOL_ZERO = 2'd0,
    FOL_TOP  = 2'd1,
    FOL_DIV  = 2'd2
  } fol_class_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic iter;
    logic div_en;
    logic mul;
    logic fin;
  } vts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } vts_sts_t;

endpackage

// ----- hw/rtl/vehicle_target_speed_core.sv -----
// ----------------------------------------------------------------------------
// vehicle_target_speed_core
// Target speed per vehicle from car following and the red-light stop line.
// ----------------------------------------------------------------------------
// From input accept to output valid a word passes setup, 21 root steps with
// the 16 divider steps alongside in the shared loop, multiply and finish.
// A new word is taken only once the last is handed to the output register.
// An output word may wait in its register while the next word is processed.
// Reset (rst_n low, synchronous) restores register defaults and zeroes leader.
module vehicle_target_speed_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_first_in_road,
  input  logic [23:0] in_road_length_mm,
  input  logic [16:0] in_road_speed_limit,
  input  logic        in_light_green,
  input  logic [23:0] in_position_mm,
  input  logic [15:0] in_vehicle_length_mm,
  input  logic [16:0] in_current_speed,
  input  logic [16:0] in_top_speed,
  input  logic        in_ignores_lights,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] out_target_speed
);
  import vts_pkg::*;

  vts_cmd_t cmd;
  vts_sts_t sts;

  vts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vts_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_first_in_road     (in_first_in_road),
    .in_road_length_mm    (in_road_length_mm),
    .in_road_speed_limit  (in_road_speed_limit),
    .in_light_green       (in_light_green),
    .in_position_mm       (in_position_mm),
    .in_vehicle_length_mm (in_vehicle_length_mm),
    .in_current_speed     (in_current_speed),
    .in_top_speed         (in_top_speed),
    .in_ignores_lights    (in_ignores_lights),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_target_speed     (out_target_speed)
  );

endmodule

// ----- hw/rtl/vts_ctrl.sv -----
// ----------------------------------------------------------------------------
// vts_ctrl
// Sequencer: capture, prepare, shared iteration of divider and root, multiply,
// then hand the word to the output register.
// ----------------------------------------------------------------------------
module vts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vts_pkg::vts_sts_t sts,
  output vts_pkg::vts_cmd_t cmd
);
  import vts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PREP = 5'b00010,
    S_ITER = 5'b00100,
    S_MUL  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;

  // Next state and step counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PREP;
      end
      S_PREP: begin
        state_nxt = S_ITER;
        cnt_nxt   = '0;
      end
      S_ITER: begin
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_r == CntW'(SqrtSteps - 1)) state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Commands to the datapath.
  assign in_ready   = (state_r == S_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.prep   = (state_r == S_PREP);
  assign cmd.iter   = (state_r == S_ITER);
  assign cmd.div_en = (state_r == S_ITER) && (cnt_r < CntW'(DivSteps));
  assign cmd.mul    = (state_r == S_MUL);
  assign cmd.fin    = (state_r == S_FIN) && sts.out_free;

endmodule

// ----- hw/rtl/vts_dp.sv -----
// ----------------------------------------------------------------------------
// vts_dp
// Datapath: configuration registers, leader state, gap and stop-line setup,
// radix-2 divider, two-bit-per-step square root, scaling multiply and the
// output register.
// ----------------------------------------------------------------------------
module vts_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  vts_pkg::vts_cmd_t cmd,
  output vts_pkg::vts_sts_t sts,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [23:0]       cfg_wdata,
  input  logic              in_first_in_road,
  input  logic [23:0]       in_road_length_mm,
  input  logic [16:0]       in_road_speed_limit,
  input  logic              in_light_green,
  input  logic [23:0]       in_position_mm,
  input  logic [15:0]       in_vehicle_length_mm,
  input  logic [16:0]       in_current_speed,
  input  logic [16:0]       in_top_speed,
  input  logic              in_ignores_lights,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [16:0]       out_target_speed
);
  import vts_pkg::*;

  // Configuration registers.
  logic [15:0] min_gap_r;
  logic [13:0] headway_r;
  logic [23:0] stop_react_r;
  logic [15:0] decel_r;
  logic [23:0] stop_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_gap_r    <= 16'd2000;
      headway_r    <= 14'd1500;
      stop_react_r <= 24'd50000;
      decel_r      <= 16'd3000;
      stop_off_r   <= 24'd200000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_GAP:     min_gap_r    <= cfg_wdata[15:0];
        REG_HEADWAY:     headway_r    <= cfg_wdata[13:0];
        REG_STOP_REACT:  stop_react_r <= cfg_wdata;
        REG_DECEL:       decel_r      <= cfg_wdata[15:0];
        REG_STOP_OFFSET: stop_off_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Captured input word.
  logic        first_r, green_r, exempt_r;
  logic [23:0] road_r, pos_r;
  logic [15:0] vlen_r;
  logic [16:0] limit_r, speed_r, top_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      first_r  <= in_first_in_road;
      road_r   <= in_road_length_mm;
      limit_r  <= in_road_speed_limit;
      green_r  <= in_light_green;
      pos_r    <= in_position_mm;
      vlen_r   <= in_vehicle_length_mm;
      speed_r  <= in_current_speed;
      top_r    <= in_top_speed;
      exempt_r <= in_ignores_lights;
    end
  end

  // Leader state, replaced by the current vehicle during setup.
  logic [23:0] lpos_r;
  logic [15:0] llen_r;
  logic [16:0] lspd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lpos_r <= '0;
      llen_r <= '0;
      lspd_r <= '0;
    end else if (cmd.prep) begin
      lpos_r <= pos_r;
      llen_r <= vlen_r;
      lspd_r <= speed_r;
    end
  end

  // Setup: bumper gap, desired gap test, stop-line distance and root operand.
  logic signed [25:0] gap, gap_over, stop_dist;
  logic        [30:0] span;
  logic        [34:0] gap_k, num_k;
  logic        [32:0] want_k;
  fol_class_t         fcls;

  always_comb begin
    gap      = $signed({2'b0, lpos_r}) - $signed({10'b0, llen_r}) - $signed({2'b0, pos_r});
    gap_over = gap - $signed({10'b0, min_gap_r});
    span     = 31'(speed_r * headway_r);
    gap_k    = 35'(gap[24:0] * 25'd1000);
    want_k   = 33'(min_gap_r * 26'd1000) + {2'b0, span};
    num_k    = 35'(gap_over[24:0] * 25'd1000);
    stop_dist = $signed({2'b0, road_r}) - $signed({2'b0, pos_r}) -
                $signed({2'b0, stop_off_r});
    if (gap <= $signed({10'b0, min_gap_r})) begin
      fcls = FOL_ZERO;
    end else if (gap_k >= {2'b0, want_k}) begin
      fcls = FOL_TOP;
    end else begin
      fcls = FOL_DIV;
    end
  end

  fol_class_t  fcls_r;
  logic        use_fol_r, use_stop_r, dpos_r;
  logic [30:0] span_r;
  logic [16:0] spd_prev_r;
  logic [31:0] rem_r;
  logic [15:0] q_r;
  logic [41:0] x_r;
  logic [23:0] srem_r;
  logic [20:0] root_r;
  logic [16:0] fspd_r;

  // Divider and square root steps.
  logic [31:0] rem_sh;
  logic [23:0] srem_sh;
  logic [22:0] trial;

  always_comb begin
    rem_sh  = {rem_r[30:0], 1'b0};
    srem_sh = {srem_r[21:0], x_r[41:40]};
    trial   = {root_r, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      fcls_r     <= fcls;
      use_fol_r  <= !first_r;
      use_stop_r <= first_r && !green_r && !exempt_r &&
                    (stop_dist < $signed({2'b0, stop_react_r}));
      dpos_r     <= (stop_dist > 26'sd0);
      span_r     <= span;
      spd_prev_r <= lspd_r;
      rem_r      <= num_k[31:0];
      q_r        <= '0;
      x_r        <= {1'b0, 41'({decel_r, 1'b0} * stop_dist[23:0])};
      srem_r     <= '0;
      root_r     <= '0;
    end else if (cmd.iter) begin
      if (cmd.div_en) begin
        if (rem_sh >= {1'b0, span_r}) begin
          rem_r <= rem_sh - {1'b0, span_r};
          q_r   <= {q_r[14:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          q_r   <= {q_r[14:0], 1'b0};
        end
      end
      x_r <= {x_r[39:0], 2'b00};
      if (srem_sh >= {1'b0, trial}) begin
        srem_r <= srem_sh - {1'b0, trial};
        root_r <= {root_r[19:0], 1'b1};
      end else begin
        srem_r <= srem_sh;
        root_r <= {root_r[19:0], 1'b0};
      end
    end
  end

  // Leader speed scaled by the gap ratio.
  logic [32:0] prod;
  assign prod = spd_prev_r * q_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) fspd_r <= prod[32:16];
  end

  // Final minimum of the limits.
  logic [16:0] res, fol_v;
  logic [20:0] stop_v;

  always_comb begin
    res = (top_r < limit_r) ? top_r : limit_r;
    unique case (fcls_r)
      FOL_ZERO: fol_v = '0;
      FOL_TOP:  fol_v = top_r;
      FOL_DIV:  fol_v = fspd_r;
      default:  fol_v = '0;
    endcase
    if (use_fol_r && (fol_v < res)) res = fol_v;
    stop_v = dpos_r ? root_r : '0;
    if (use_stop_r && (stop_v < {4'b0, res})) res = stop_v[16:0];
  end

  // Output register.
  logic        ovalid_r;
  logic [16:0] odata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.fin) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) odata_r <= res;
  end

  assign sts.out_free     = !ovalid_r || out_ready;
  assign out_valid        = ovalid_r;
  assign out_target_speed = odata_r;

endmodule

// ----- hw/rtl/vts_checker.sv -----
// ----------------------------------------------------------------------------
// vts_checker
// Port-level checks of the vehicle target speed core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [16:0] out_target_speed
);

  // The core takes one word at a time.
  `ASSERT_CLK_RST(a_one_at_a_time, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "accepted twice")

  // A result needs the iteration loop, so it never follows an accept directly.
  `ASSERT_CLK_RST(a_no_early_out, clk, rst_n, $rose(out_valid) |-> !$past(in_valid && in_ready), "result too early")

  // A stalled result holds.
  `ASSERT_CLK_RST(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_target_speed)), "stalled result changed")

  // Nothing is shown right out of reset.
  `ASSERT_CLK(a_reset_quiet, clk, $past(!rst_n) |-> !out_valid, "output valid after reset")

endmodule

bind vehicle_target_speed_core vts_checker u_vts_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_target_speed (out_target_speed)
);

// ----- verif/vehicle_target_speed_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vehicle_target_speed_checker
// Watches the vehicle and result channels of the target speed block, predicts
// each target speed from its own copy of the leader state and registers, and
// compares every result word against the oldest prediction in order.
// ----------------------------------------------------------------------------
module vehicle_target_speed_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_first_in_road,
  input  logic [23:0] in_road_length_mm,
  input  logic [16:0] in_road_speed_limit,
  input  logic        in_light_green,
  input  logic [23:0] in_position_mm,
  input  logic [15:0] in_vehicle_length_mm,
  input  logic [16:0] in_current_speed,
  input  logic [16:0] in_top_speed,
  input  logic        in_ignores_lights,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [16:0] out_target_speed,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);
  import vts_pkg::*;

  logic [15:0] min_gap;
  logic [13:0] headway;
  logic [23:0] stop_react;
  logic [15:0] decel;
  logic [23:0] stop_offset;
  logic [23:0] lead_pos;
  logic [15:0] lead_len;
  logic [16:0] lead_spd;
  logic [16:0] speed_queue[$];

  // Bitwise integer square root, floor.
  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Target speed for one vehicle given the current leader and registers.
  function automatic logic [16:0] target_speed(
    logic first, logic [23:0] road_len, logic [16:0] limit, logic green,
    logic [23:0] pos, logic [16:0] spd, logic [16:0] top, logic exempt);
    longint gap, stop_dist;
    longint unsigned want, fol, span, ratio, cap;
    want = (top < limit) ? top : limit;
    if (!first) begin
      gap = longint'(lead_pos) - longint'(lead_len) - longint'(pos);
      span = longint'(spd) * longint'(headway);
      if (gap <= longint'(min_gap)) fol = 0;
      else if (longint'(gap) * 1000 >= longint'(min_gap) * 1000 + span) fol = top;
      else begin
        ratio = ((longint'(gap - longint'(min_gap)) * 1000) << 16) / span;
        fol = (longint'(lead_spd) * ratio) >> 16;
      end
      if (fol < want) want = fol;
    end
    if (first && !green && !exempt) begin
      stop_dist = longint'(road_len) - longint'(pos) - longint'(stop_offset);
      if (stop_dist < longint'(stop_react)) begin
        cap = 0;
        if (stop_dist > 0) cap = isqrt(2 * longint'(decel) * stop_dist);
        if (cap < want) want = cap;
      end
    end
    return want[16:0];
  endfunction

  assign pending_count = speed_queue.size();

  // Track registers, predict on each accepted word and check each result word.
  always @(posedge clk) begin
    if (!rst_n) begin
      min_gap <= 16'd2000;
      headway <= 14'd1500;
      stop_react <= 24'd50000;
      decel <= 16'd3000;
      stop_offset <= 24'd200000;
      lead_pos <= '0;
      lead_len <= '0;
      lead_spd <= '0;
      fail_count <= 0;
      result_count <= 0;
      speed_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_GAP: min_gap <= cfg_wdata[15:0];
          REG_HEADWAY: headway <= cfg_wdata[13:0];
          REG_STOP_REACT: stop_react <= cfg_wdata;
          REG_DECEL: decel <= cfg_wdata[15:0];
          REG_STOP_OFFSET: stop_offset <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        speed_queue.push_back(target_speed(in_first_in_road, in_road_length_mm,
          in_road_speed_limit, in_light_green, in_position_mm, in_current_speed,
          in_top_speed, in_ignores_lights));
        lead_pos <= in_position_mm;
        lead_len <= in_vehicle_length_mm;
        lead_spd <= in_current_speed;
      end
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (speed_queue.size() == 0) begin
          $error("Unexpected result word: target_speed actual %0d", out_target_speed);
          fail_count <= fail_count + 1;
        end else begin
          if (speed_queue[0] !== out_target_speed) begin
            $error("target_speed expected %0d actual %0d", speed_queue[0],
              out_target_speed);
            fail_count <= fail_count + 1;
          end
          void'(speed_queue.pop_front());
        end
      end
    end
  end
endmodule

// ----- verif/vehicle_target_speed_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vehicle_target_speed_core_test
// Drives roads of vehicles through the target speed block under several
// register settings and idling patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module vehicle_target_speed_core_test;
  import vts_pkg::*;

  localparam int Latency = 25;
  localparam int CycleLimit = 600000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_first_in_road = 1'b0;
  logic [23:0] in_road_length_mm = '0;
  logic [16:0] in_road_speed_limit = '0;
  logic        in_light_green = 1'b0;
  logic [23:0] in_position_mm = '0;
  logic [15:0] in_vehicle_length_mm = '0;
  logic [16:0] in_current_speed = '0;
  logic [16:0] in_top_speed = '0;
  logic        in_ignores_lights = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] out_target_speed;

  int fail_count, pending_count, result_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;
  int hold_cycles = 0;
  logic hold_taken = 1'b0;
  int cycle_count = 0;
  int word_count = 0;
  int road_pos;

  always #5 clk = ~clk;

  vehicle_target_speed_core u_dut (.*);

  vehicle_target_speed_checker u_check (.*);

  // Receiver: random stalls, plus one long hold-off once it is requested.
  always @(posedge clk) begin
    if ((hold_len > 0) && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cycles <= hold_len;
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one vehicle word and hold it until accepted.
  task automatic send_vehicle(logic first, logic [23:0] road_len, logic [16:0] limit,
    logic green, logic [23:0] pos, logic [15:0] vlen, logic [16:0] spd,
    logic [16:0] top, logic exempt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_in_road <= first;
    in_road_length_mm <= road_len;
    in_road_speed_limit <= limit;
    in_light_green <= green;
    in_position_mm <= pos;
    in_vehicle_length_mm <= vlen;
    in_current_speed <= spd;
    in_top_speed <= top;
    in_ignores_lights <= exempt;
    do @(posedge clk); while (!in_ready);
    word_count++;
  endtask

  // Wait for every expected speed, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  // One road: a front vehicle mostly near the stop line, then followers at random gaps.
  task automatic send_road(int cars);
    logic [23:0] road_len, pos;
    logic [16:0] limit;
    logic green;
    int step;
    road_len = $urandom_range(16777215, 100000);
    limit = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(100000));
    green = $urandom_range(1);
    pos = road_len - 24'($urandom_range(300000));
    if ($urandom_range(4) == 0) pos = 24'($urandom);
    for (int k = 0; k < cars; k++) begin
      send_vehicle(k == 0, road_len, limit, green, pos, 16'($urandom_range(8000)),
        ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(100000)),
        ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(100000)),
        $urandom_range(3) == 0);
      step = $urandom_range(80000);
      pos = (pos > step) ? pos - 24'(step) : 24'($urandom_range(5000));
    end
  endtask

  task automatic random_phase(int words);
    int sent;
    sent = 0;
    while (sent < words) begin
      if ($urandom_range(9) == 0) begin
        // Noise word with fully random fields.
        send_vehicle($urandom_range(1), 24'($urandom), 17'($urandom), $urandom_range(1),
          24'($urandom), 16'($urandom), 17'($urandom), 17'($urandom), $urandom_range(1));
        sent++;
      end else begin
        road_pos = $urandom_range(8, 1);
        send_road(road_pos);
        sent += road_pos;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: follower before any leader, then extremes under reset values.
    send_vehicle(1'b0, 24'd1000000, 17'd100000, 1'b1, 24'd500, 16'd4000, 17'd20000,
      17'd30000, 1'b0);
    send_vehicle(1'b1, 24'd1000000, 17'd100000, 1'b0, 24'd770000, 16'd4500, 17'd15000,
      17'd90000, 1'b0);
    send_vehicle(1'b0, 24'd1000000, 17'd100000, 1'b0, 24'd764000, 16'd4000, 17'd20000,
      17'd90000, 1'b0);
    send_vehicle(1'b0, 24'd1000000, 17'd100000, 1'b0, 24'd757000, 16'd4000, 17'd10000,
      17'd90000, 1'b0);
    send_vehicle(1'b0, 24'd1000000, 17'd100000, 1'b0, 24'd600000, 16'd4000, 17'd0,
      17'd90000, 1'b0);
    send_vehicle(1'b1, 24'd1000000, 17'd100000, 1'b0, 24'd810000, 16'd4000, 17'd0,
      17'd100000, 1'b0);
    send_vehicle(1'b1, 24'd1000000, 17'd100000, 1'b0, 24'd810000, 16'd4000, 17'd0,
      17'd100000, 1'b1);
    send_vehicle(1'b1, 24'd1000000, 17'd100000, 1'b0, 24'd760000, 16'd0, 17'd0,
      17'd100000, 1'b0);
    send_vehicle(1'b1, 24'hFFFFFF, 17'h1FFFF, 1'b1, 24'hFFFFFF, 16'hFFFF, 17'h1FFFF,
      17'h1FFFF, 1'b1);
    send_vehicle(1'b0, 24'd0, 17'h1FFFF, 1'b0, 24'd0, 16'd0, 17'h1FFFF, 17'h1FFFF, 1'b0);
    send_vehicle(1'b1, 24'd0, 17'd0, 1'b0, 24'hFFFFFF, 16'hFFFF, 17'd0, 17'd0, 1'b0);
    drain();

    // Extreme settings: zero headway and deceleration, widest distances.
    cfg_write(REG_MIN_GAP, 24'd0);
    cfg_write(REG_HEADWAY, 24'd0);
    cfg_write(REG_STOP_REACT, 24'hFFFFFF);
    cfg_write(REG_DECEL, 24'd0);
    cfg_write(REG_STOP_OFFSET, 24'd0);
    cfg_write(3'd7, 24'hFFFFFF);
    send_vehicle(1'b1, 24'd900000, 17'd50000, 1'b0, 24'd100, 16'd3000, 17'd5000,
      17'd60000, 1'b0);
    send_vehicle(1'b0, 24'd900000, 17'd50000, 1'b0, 24'd50, 16'd3000, 17'd5000,
      17'd60000, 1'b0);
    random_phase(150);
    drain();

    // Large gap, headway, deceleration and offset, zero stop reaction, with frequent receiver stalls.
    cfg_write(REG_MIN_GAP, 24'hFFFF);
    cfg_write(REG_HEADWAY, 24'd10000);
    cfg_write(REG_STOP_REACT, 24'd0);
    cfg_write(REG_DECEL, 24'hFFFF);
    cfg_write(REG_STOP_OFFSET, 24'hFFFFFF);
    recv_stall_pct = 67;
    random_phase(120);
    drain();

    // Typical settings with the sender idling, and a long receiver hold-off.
    cfg_write(REG_MIN_GAP, 24'd1500);
    cfg_write(REG_HEADWAY, 24'd1200);
    cfg_write(REG_STOP_REACT, 24'd80000);
    cfg_write(REG_DECEL, 24'd1);
    cfg_write(REG_STOP_OFFSET, 24'd150000);
    recv_stall_pct = 0;
    send_idle_pct = 67;
    random_phase(150);
    send_idle_pct = 0;
    hold_len = 400;
    random_phase(40);
    drain();

    // Back to reset values, first with both sides idling, then with neither.
    cfg_write(REG_MIN_GAP, 24'd2000);
    cfg_write(REG_HEADWAY, 24'd1500);
    cfg_write(REG_STOP_REACT, 24'd50000);
    cfg_write(REG_DECEL, 24'd3000);
    cfg_write(REG_STOP_OFFSET, 24'd200000);
    send_idle_pct = 30;
    recv_stall_pct = 30;
    random_phase(200);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_phase(180);
    drain();

    $display("Sent %0d vehicle words over five register settings and four idling modes;",
      word_count);
    $display("checked %0d target speed words.", result_count);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/vts_pkg.sv
hw/rtl/vts_ctrl.sv
hw/rtl/vts_dp.sv
hw/rtl/vehicle_target_speed_core.sv
hw/rtl/vts_checker.sv
verif/vehicle_target_speed_checker.sv
verif/vehicle_target_speed_core_test.sv
